// ===== rtl/core/bsmc_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// bsmc_pkg
// Shared types and constants of the blind servo motion controller: command
// codes, direction and end codes, stop reasons, register map and the packed
// layouts of the stream words.
// ---------------------------------------------------------------------------
package bsmc_pkg;

	// sizes
	localparam int NUM_BLINDS = 8;
	localparam int NUM_CYCLES = 4;
	localparam int BLIND_W    = 3;
	localparam int CYCLE_W    = 2;
	localparam int ACYC_W     = 3;
	localparam int ANGLE_W    = 8;
	localparam int TIME_W     = 32;
	localparam int ALU_W      = 34;

	// angle limits
	localparam int ANGLE_MID = 90;
	localparam int ANGLE_MAX = 180;

	// configuration port
	localparam int APB_ADDR_W = 6;
	localparam int APB_DATA_W = 64;
	localparam int REG_IDX_W  = 3;
	localparam int CW_W       = 42;
	localparam int CW_SPD_LSB = 2;
	localparam int CW_DUR_LSB = 10;

	localparam logic [63:0] CENTER_RESET = 64'd6510615555426900570;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_CENTER   = 3'd0,
		REG_TIMEOUT  = 3'd1,
		REG_ENDSTOPS = 3'd2,
		REG_CYCLE0   = 3'd3
	} reg_idx_t;

	// command codes carried in tuser
	typedef enum logic [2:0] {
		FN_TICK     = 3'd0,
		FN_UP       = 3'd1,
		FN_DOWN     = 3'd2,
		FN_UPDOWN   = 3'd3,
		FN_RUN      = 3'd4,
		FN_STOP     = 3'd5,
		FN_STOP_ALL = 3'd6,
		FN_UNUSED   = 3'd7
	} func_t;

	typedef enum logic [1:0] {
		DIR_NONE = 2'd0,
		DIR_UP   = 2'd1,
		DIR_DOWN = 2'd2,
		DIR_BAD  = 2'd3
	} dir_t;

	typedef enum logic [1:0] {
		END_UNKNOWN = 2'd0,
		END_TOP     = 2'd1,
		END_BOTTOM  = 2'd2
	} end_t;

	typedef enum logic [2:0] {
		RSN_SYSTEM     = 3'd0,
		RSN_TIMEOUT    = 3'd1,
		RSN_BOTTOM_END = 3'd2,
		RSN_TOP_END    = 3'd3,
		RSN_AT_BOTTOM  = 3'd4,
		RSN_AT_TOP     = 3'd5
	} reason_t;

	// input word, last member in the lowest bits
	typedef struct packed {
		logic                pad;
		logic [7:0]          top_switches;
		logic [7:0]          bottom_switches;
		logic [TIME_W-1:0]   now;
		logic [CYCLE_W-1:0]  cycle_index;
		logic [7:0]          speed;
		logic [TIME_W-1:0]   move_time;
		logic [1:0]          direction;
		logic [BLIND_W-1:0]  blind;
	} in_word_t;

	localparam int IN_DATA_W = $bits(in_word_t);

	// result word, last member in the lowest bits
	typedef struct packed {
		logic [1:0]          pad;
		logic [2:0]          stop_reason;
		logic                stopped_now;
		logic [1:0]          absolute_end;
		logic [1:0]          relative_end;
		logic [1:0]          motion;
		logic                pwm_enabled;
		logic [ANGLE_W-1:0]  servo_angle;
		logic [BLIND_W-1:0]  out_blind;
	} out_word_t;

	localparam int OUT_DATA_W = $bits(out_word_t);

	// sequencer states
	typedef enum logic [8:0] {
		ST_IDLE     = 9'b000000001,
		ST_DISPATCH = 9'b000000010,
		ST_HALT     = 9'b000000100,
		ST_EVAL1    = 9'b000001000,
		ST_EVAL2    = 9'b000010000,
		ST_EVAL3    = 9'b000100000,
		ST_ADD      = 9'b001000000,
		ST_ANGLE    = 9'b010000000,
		ST_EMIT     = 9'b100000000
	} state_t;

endpackage
`default_nettype wire

// ===== rtl/core/blind_servo_motion_controller.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// blind_servo_motion_controller
// Per-blind continuous-servo motion controller: moves, refusals, timeouts,
// endstop stops and PWM inactivity, on one shared adder under a sequencer.
// ---------------------------------------------------------------------------
// Usage
//  Commands enter on the slave stream: tuser is the command code, tdata the
//  operands. Each command gives one result word per blind it touches on the
//  master stream; tlast marks the final word of a command. Tick and stop_all
//  give one word per blind in blind order; other commands give one word;
//  the unused code and an out-of-range blind give none.
//  All steps share one 34-bit add/subtract unit. A tick per blind: deadline
//  check, inactivity difference, its compare, result; stop_all per blind:
//  halt, result; an up or down move: dispatch, deadline add, angle, result;
//  a refusal: dispatch, result; a stop: halt, result. s_tready is high only
//  while the sequencer is idle.
//  The result register lets the sequencer run on while the last word waits;
//  a stalled receiver holds the sequencer at its next result word.
//  Reset clears all blind state and loads the register reset values.
//  Registers sit on the APB port at byte address 8*i; writes only while idle.
// ---------------------------------------------------------------------------
module blind_servo_motion_controller (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// configuration port
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [bsmc_pkg::APB_ADDR_W-1:0] paddr,
	input  wire logic [bsmc_pkg::APB_DATA_W-1:0] pwdata,
	output logic      [bsmc_pkg::APB_DATA_W-1:0] prdata,
	output logic                                 pready,
	// command stream
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	// blind, direction, move_time, speed, cycle_index, now, bottom_switches,
	// top_switches, zero pad
	input  wire logic [bsmc_pkg::IN_DATA_W-1:0]  s_tdata,
	// func
	input  wire logic [2:0]                      s_tuser,
	// result stream
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	// out_blind, servo_angle, pwm_enabled, motion, relative_end, absolute_end,
	// stopped_now, stop_reason, zero pad
	output logic      [bsmc_pkg::OUT_DATA_W-1:0] m_tdata,
	output logic                                 m_tlast
);
	import bsmc_pkg::*;

	// configuration registers
	logic [63:0]        center_q;
	logic [TIME_W-1:0]  timeout_q;
	logic               endstops_q;
	logic [CW_W-1:0]    cycle_q [NUM_CYCLES];

	// blind state
	logic [1:0]         motion_q   [NUM_BLINDS];
	logic [TIME_W-1:0]  deadline_q [NUM_BLINDS];
	logic [ACYC_W-1:0]  acyc_q     [NUM_BLINDS];
	logic [1:0]         rel_q      [NUM_BLINDS];
	logic [1:0]         abs_q      [NUM_BLINDS];
	logic               pwm_q      [NUM_BLINDS];
	logic [ANGLE_W-1:0] angle_q    [NUM_BLINDS];

	// command latch and sequencer
	state_t             state_q;
	func_t              func_q;
	in_word_t           cmd_q;
	logic [BLIND_W-1:0] ptr_q;
	logic               multi_q;
	logic               stopped_q;
	reason_t            reason_q;
	logic [1:0]         mv_dir_q;
	logic [TIME_W-1:0]  dur_q;
	logic [7:0]         spd_q;
	logic [TIME_W-1:0]  diff_q;
	logic               late_q;

	// result register
	logic               m_tvalid_q;
	out_word_t          m_word_q;
	logic               m_tlast_q;

	logic [REG_IDX_W-1:0] reg_idx;
	logic                 cfg_wr;
	logic                 s_fire;
	in_word_t             s_word;

	assign reg_idx  = paddr[APB_ADDR_W-1 -: REG_IDX_W];
	assign cfg_wr   = psel & penable & pwrite;
	assign pready   = 1'b1;
	assign s_tready = (state_q == ST_IDLE);
	assign s_fire   = s_tvalid & s_tready;
	assign s_word   = in_word_t'(s_tdata);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_word_q;
	assign m_tlast  = m_tlast_q;

	// register read-back
	always_comb begin
		prdata = '0;
		if (reg_idx == REG_CENTER) begin
			prdata = center_q;
		end else if (reg_idx == REG_TIMEOUT) begin
			prdata = {{(APB_DATA_W-TIME_W){1'b0}}, timeout_q};
		end else if (reg_idx == REG_ENDSTOPS) begin
			prdata = {{(APB_DATA_W-1){1'b0}}, endstops_q};
		end else begin
			for (int i = 0; i < NUM_CYCLES; i++) begin
				if (reg_idx == REG_IDX_W'(int'(REG_CYCLE0) + i)) begin
					prdata = {{(APB_DATA_W-CW_W){1'b0}}, cycle_q[i]};
				end
			end
		end
	end

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_q   <= CENTER_RESET;
			timeout_q  <= '0;
			endstops_q <= 1'b1;
			for (int i = 0; i < NUM_CYCLES; i++) begin
				cycle_q[i] <= '0;
			end
		end else if (cfg_wr) begin
			if (reg_idx == REG_CENTER) begin
				center_q <= pwdata;
			end else if (reg_idx == REG_TIMEOUT) begin
				timeout_q <= pwdata[TIME_W-1:0];
			end else if (reg_idx == REG_ENDSTOPS) begin
				endstops_q <= pwdata[0];
			end else begin
				for (int i = 0; i < NUM_CYCLES; i++) begin
					if (reg_idx == REG_IDX_W'(int'(REG_CYCLE0) + i)) begin
						cycle_q[i] <= pwdata[CW_W-1:0];
					end
				end
			end
		end
	end

	// current blind view
	logic [ANGLE_W-1:0] center;
	logic [ANGLE_W-1:0] center_sat;
	logic [1:0]         cur_motion;
	logic [1:0]         cur_rel;
	logic [ACYC_W-1:0]  cur_acyc;
	logic               bot_hit;
	logic               top_hit;

	assign center     = center_q[{ptr_q, 3'b000} +: ANGLE_W];
	assign center_sat = (center > ANGLE_W'(ANGLE_MAX)) ? ANGLE_W'(ANGLE_MAX) : center;
	assign cur_motion = motion_q[ptr_q];
	assign cur_rel    = rel_q[ptr_q];
	assign cur_acyc   = acyc_q[ptr_q];
	assign bot_hit    = endstops_q & cmd_q.bottom_switches[ptr_q];
	assign top_hit    = endstops_q & cmd_q.top_switches[ptr_q];

	// shared add/subtract unit
	logic [ALU_W-1:0] alu_a;
	logic [ALU_W-1:0] alu_b;
	logic             alu_sub;
	logic [ALU_W-1:0] alu_res;
	logic             alu_neg;
	logic             alu_late;
	logic [9:0]       base;
	logic             base_wide;

	// angle base: center, or twice the center less the midpoint when shifted
	assign base_wide = ((mv_dir_q == DIR_DOWN) && (center > ANGLE_W'(ANGLE_MID)))
		|| ((mv_dir_q == DIR_UP) && (center < ANGLE_W'(ANGLE_MID)));
	assign base = base_wide ? ({1'b0, center, 1'b0} - 10'(ANGLE_MID))
		: {2'b00, center};

	always_comb begin
		alu_a   = '0;
		alu_b   = '0;
		alu_sub = 1'b0;
		unique case (state_q)
			ST_EVAL1, ST_EVAL2: begin
				alu_a   = ALU_W'(cmd_q.now);
				alu_b   = ALU_W'(deadline_q[ptr_q]);
				alu_sub = 1'b1;
			end
			ST_EVAL3: begin
				alu_a   = ALU_W'(diff_q);
				alu_b   = ALU_W'(timeout_q);
				alu_sub = 1'b1;
			end
			ST_ADD: begin
				alu_a = ALU_W'(cmd_q.now);
				alu_b = ALU_W'(dur_q);
			end
			ST_ANGLE: begin
				alu_a   = {{(ALU_W-10){base[9]}}, base};
				alu_b   = ALU_W'(spd_q);
				alu_sub = (mv_dir_q == DIR_UP);
			end
			default: begin
			end
		endcase
		alu_res = alu_a + (alu_sub ? ~alu_b : alu_b) + ALU_W'(alu_sub);
	end

	assign alu_neg  = alu_res[ALU_W-1];
	assign alu_late = !alu_neg && (alu_res[TIME_W-1:0] != '0);

	// saturated servo angle
	logic [ANGLE_W-1:0] sat_angle;
	always_comb begin
		priority if (alu_neg) begin
			sat_angle = '0;
		end else if (alu_res[ALU_W-2:0] > (ALU_W-1)'(ANGLE_MAX)) begin
			sat_angle = ANGLE_W'(ANGLE_MAX);
		end else begin
			sat_angle = alu_res[ANGLE_W-1:0];
		end
	end

	// move set-up for single-blind commands
	logic [1:0]        dp_dir;
	logic [TIME_W-1:0] dp_dur;
	logic [7:0]        dp_spd;
	logic              dp_ci_ok;
	logic [CW_W-1:0]   dp_word;
	logic              dp_go;
	logic              dp_refuse;
	reason_t           dp_reason;

	assign dp_ci_ok = ({1'b0, cmd_q.cycle_index} < (CYCLE_W+1)'(NUM_CYCLES));
	assign dp_word  = cycle_q[cmd_q.cycle_index];

	always_comb begin
		dp_dir = DIR_NONE;
		dp_dur = cmd_q.move_time;
		dp_spd = cmd_q.speed;
		unique case (func_q)
			FN_UP:     dp_dir = DIR_UP;
			FN_DOWN:   dp_dir = DIR_DOWN;
			FN_UPDOWN: dp_dir = cmd_q.direction;
			FN_RUN: begin
				if (dp_ci_ok) begin
					dp_dir = dp_word[1:0];
				end
				dp_dur = dp_word[CW_DUR_LSB +: TIME_W];
				dp_spd = dp_word[CW_SPD_LSB +: 8];
			end
			default: begin
			end
		endcase
		dp_go = (dp_dir == DIR_UP) || (dp_dir == DIR_DOWN);
		// refusal checks, in order of precedence
		dp_refuse = 1'b1;
		if (dp_dir == DIR_DOWN) begin
			priority if (cur_motion == DIR_UP) begin
				dp_reason = RSN_SYSTEM;
			end else if (bot_hit) begin
				dp_reason = RSN_BOTTOM_END;
			end else if (cur_rel == END_BOTTOM) begin
				dp_reason = RSN_AT_BOTTOM;
			end else begin
				dp_reason = RSN_SYSTEM;
				dp_refuse = 1'b0;
			end
		end else begin
			priority if (cur_motion == DIR_DOWN) begin
				dp_reason = RSN_SYSTEM;
			end else if (top_hit) begin
				dp_reason = RSN_TOP_END;
			end else if (cur_rel == END_TOP) begin
				dp_reason = RSN_AT_TOP;
			end else begin
				dp_reason = RSN_SYSTEM;
				dp_refuse = 1'b0;
			end
		end
	end

	// tick stop decision
	logic    tk_halt;
	reason_t tk_reason;
	always_comb begin
		tk_halt   = 1'b1;
		tk_reason = RSN_TIMEOUT;
		priority if (alu_late && (cur_motion != DIR_NONE)) begin
			tk_reason = RSN_TIMEOUT;
		end else if ((cur_motion == DIR_DOWN) && bot_hit) begin
			tk_reason = RSN_BOTTOM_END;
		end else if ((cur_motion == DIR_UP) && top_hit) begin
			tk_reason = RSN_TOP_END;
		end else begin
			tk_halt = 1'b0;
		end
	end

	// halt request for the current blind
	logic    halt_en;
	reason_t halt_cause;
	logic    out_free;
	logic    emit_load;
	logic    last_word;

	always_comb begin
		halt_en    = 1'b0;
		halt_cause = RSN_SYSTEM;
		unique case (state_q)
			ST_HALT: begin
				halt_en = 1'b1;
			end
			ST_EVAL1: begin
				halt_en    = tk_halt;
				halt_cause = tk_reason;
			end
			ST_DISPATCH: begin
				halt_en    = dp_go & dp_refuse;
				halt_cause = dp_reason;
			end
			default: begin
			end
		endcase
	end

	assign out_free  = !m_tvalid_q || m_tready;
	assign emit_load = (state_q == ST_EMIT) && out_free;
	assign last_word = !multi_q || (ptr_q == BLIND_W'(NUM_BLINDS-1));

	// timeout end position from the active cycle
	logic [1:0] tcyc_dir;
	logic [1:0] acyc_m1;
	assign acyc_m1  = 2'(cur_acyc - ACYC_W'(1));
	assign tcyc_dir = cycle_q[acyc_m1][1:0];

	// blind state updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_BLINDS; i++) begin
				motion_q[i]   <= DIR_NONE;
				deadline_q[i] <= '0;
				acyc_q[i]     <= '0;
				rel_q[i]      <= END_UNKNOWN;
				abs_q[i]      <= END_UNKNOWN;
				pwm_q[i]      <= 1'b0;
				angle_q[i]    <= '0;
			end
		end else begin
			// active cycle set by updown and run_cycle, a refusal clears it below
			if ((state_q == ST_DISPATCH) && !halt_en) begin
				if (func_q == FN_UPDOWN) begin
					acyc_q[ptr_q] <= '0;
				end else if ((func_q == FN_RUN) && dp_ci_ok) begin
					acyc_q[ptr_q] <= ACYC_W'(cmd_q.cycle_index) + ACYC_W'(1);
				end
			end
			if (halt_en) begin
				angle_q[ptr_q]    <= center_sat;
				motion_q[ptr_q]   <= DIR_NONE;
				deadline_q[ptr_q] <= '0;
				acyc_q[ptr_q]     <= '0;
				if (halt_cause == RSN_TIMEOUT) begin
					if (cur_acyc != '0) begin
						if (tcyc_dir == DIR_DOWN) begin
							rel_q[ptr_q] <= END_BOTTOM;
						end else if (tcyc_dir == DIR_UP) begin
							rel_q[ptr_q] <= END_TOP;
						end
					end
				end else if (halt_cause == RSN_BOTTOM_END) begin
					rel_q[ptr_q] <= END_BOTTOM;
					abs_q[ptr_q] <= END_BOTTOM;
				end else if (halt_cause == RSN_TOP_END) begin
					rel_q[ptr_q] <= END_TOP;
					abs_q[ptr_q] <= END_TOP;
				end
			end
			// inactivity switch-off
			if ((state_q == ST_EVAL3) && late_q && !alu_neg) begin
				pwm_q[ptr_q] <= 1'b0;
			end
			// move start
			if (state_q == ST_ADD) begin
				deadline_q[ptr_q] <= alu_res[TIME_W-1:0];
			end
			if (state_q == ST_ANGLE) begin
				angle_q[ptr_q]  <= sat_angle;
				pwm_q[ptr_q]    <= 1'b1;
				motion_q[ptr_q] <= mv_dir_q;
			end
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			multi_q   <= 1'b0;
			ptr_q     <= '0;
			stopped_q <= 1'b0;
			reason_q  <= RSN_SYSTEM;
			func_q    <= FN_TICK;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_fire) begin
						func_q    <= func_t'(s_tuser);
						stopped_q <= 1'b0;
						reason_q  <= RSN_SYSTEM;
						priority if (func_t'(s_tuser) == FN_TICK) begin
							ptr_q   <= '0;
							multi_q <= 1'b1;
							state_q <= ST_EVAL1;
						end else if (func_t'(s_tuser) == FN_STOP_ALL) begin
							ptr_q   <= '0;
							multi_q <= 1'b1;
							state_q <= ST_HALT;
						end else if ((func_t'(s_tuser) == FN_UNUSED)
							|| ({1'b0, s_word.blind} >= (BLIND_W+1)'(NUM_BLINDS))) begin
							state_q <= ST_IDLE;
						end else if (func_t'(s_tuser) == FN_STOP) begin
							ptr_q   <= s_word.blind;
							multi_q <= 1'b0;
							state_q <= ST_HALT;
						end else begin
							ptr_q   <= s_word.blind;
							multi_q <= 1'b0;
							state_q <= ST_DISPATCH;
						end
					end
				end
				ST_HALT: begin
					stopped_q <= 1'b1;
					reason_q  <= RSN_SYSTEM;
					state_q   <= ST_EMIT;
				end
				ST_DISPATCH: begin
					if (dp_go && dp_refuse) begin
						stopped_q <= 1'b1;
						reason_q  <= dp_reason;
						state_q   <= ST_EMIT;
					end else if (dp_go) begin
						state_q <= ST_ADD;
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_EVAL1: begin
					if (tk_halt) begin
						stopped_q <= 1'b1;
						reason_q  <= tk_reason;
					end
					state_q <= ST_EVAL2;
				end
				ST_EVAL2: begin
					state_q <= ST_EVAL3;
				end
				ST_EVAL3: begin
					state_q <= ST_EMIT;
				end
				ST_ADD: begin
					state_q <= ST_ANGLE;
				end
				ST_ANGLE: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						if (last_word) begin
							state_q <= ST_IDLE;
						end else begin
							ptr_q     <= ptr_q + BLIND_W'(1);
							stopped_q <= 1'b0;
							reason_q  <= RSN_SYSTEM;
							state_q   <= (func_q == FN_TICK) ? ST_EVAL1 : ST_HALT;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// command operands and per-step working registers
	always_ff @(posedge clk) begin
		if (s_fire) begin
			cmd_q <= s_word;
		end
		if (state_q == ST_DISPATCH) begin
			mv_dir_q <= dp_dir;
			dur_q    <= dp_dur;
			spd_q    <= dp_spd;
		end
		if (state_q == ST_EVAL2) begin
			diff_q <= alu_res[TIME_W-1:0];
			late_q <= alu_late;
		end
	end

	// result word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (emit_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// result word payload
	always_ff @(posedge clk) begin
		if (emit_load) begin
			m_word_q.pad          <= '0;
			m_word_q.stop_reason  <= reason_q;
			m_word_q.stopped_now  <= stopped_q;
			m_word_q.absolute_end <= abs_q[ptr_q];
			m_word_q.relative_end <= rel_q[ptr_q];
			m_word_q.motion       <= motion_q[ptr_q];
			m_word_q.pwm_enabled  <= pwm_q[ptr_q];
			m_word_q.servo_angle  <= angle_q[ptr_q];
			m_word_q.out_blind    <= ptr_q;
			m_tlast_q             <= last_word;
		end
	end

endmodule
`default_nettype wire

// ===== bench/blind_servo_motion_controller_tb.sv =====
// ---------------------------------------------------------------------------
// blind_servo_motion_controller_tb
// Self-checking bench for the blind servo motion controller. Commands are
// streamed in from a queue with random gaps. A behavioural model of every
// blind predicts the result words of each accepted command, and the result
// stream is compared with them field by field under random back-pressure.
// Phases between register writes cover the extreme and random settings.
// ---------------------------------------------------------------------------
module blind_servo_motion_controller_tb;
	import bsmc_pkg::*;

	typedef struct {
		func_t    fn;
		in_word_t w;
	} blind_cmd_t;

	typedef struct {
		out_word_t w;
		logic      last;
	} blind_report_t;

	// clock and reset
	logic clk = 1'b0;
	logic arst_n = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// block ports
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic [2:0]            s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tlast;

	blind_servo_motion_controller u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	// bench bookkeeping
	blind_cmd_t    cmd_queue[$];
	blind_report_t reports_due[$];
	int            n_errors = 0;
	int            cmds_queued = 0;
	int            cmds_taken = 0;
	logic          s_fire = 1'b0;
	logic          m_fire = 1'b0;
	bit            steady = 1'b0;
	int            src_wait = 0;
	int            rx_wait = 0;
	int            rx_words = 0;
	int            stall_left = 0;
	bit            stall_done = 1'b0;
	logic [31:0]   clock_ms = '0;

	// mirrored registers
	logic [63:0]   center_tbl = CENTER_RESET;
	logic [31:0]   idle_timeout = '0;
	logic          switch_stops = 1'b1;
	logic [CW_W-1:0] cycle_set[NUM_CYCLES] = '{default: '0};

	// per-blind model state
	dir_t          spin[NUM_BLINDS] = '{default: DIR_NONE};
	logic [31:0]   due[NUM_BLINDS] = '{default: '0};
	logic [2:0]    preset[NUM_BLINDS] = '{default: '0};
	end_t          rel_pos[NUM_BLINDS] = '{default: END_UNKNOWN};
	end_t          abs_pos[NUM_BLINDS] = '{default: END_UNKNOWN};
	logic          pwm_att[NUM_BLINDS] = '{default: 1'b0};
	logic [7:0]    angle_now[NUM_BLINDS] = '{default: '0};

	function automatic int center_of(int b);
		return int'(center_tbl[8*b +: 8]);
	endfunction

	// stop a blind: centre the servo, clear motion, mark ends by cause
	function automatic void park(int b, reason_t why);
		int   c;
		dir_t d;
		c = center_of(b);
		angle_now[b] = (c > ANGLE_MAX) ? 8'(ANGLE_MAX) : 8'(c);
		spin[b] = DIR_NONE;
		if (why == RSN_TIMEOUT) begin
			if (preset[b] != 0) begin
				d = dir_t'(cycle_set[preset[b] - 1][1:0]);
				if (d == DIR_DOWN) rel_pos[b] = END_BOTTOM;
				else if (d == DIR_UP) rel_pos[b] = END_TOP;
			end
		end else if (why == RSN_BOTTOM_END) begin
			rel_pos[b] = END_BOTTOM;
			abs_pos[b] = END_BOTTOM;
		end else if (why == RSN_TOP_END) begin
			rel_pos[b] = END_TOP;
			abs_pos[b] = END_TOP;
		end
		due[b] = '0;
		preset[b] = '0;
	endfunction

	// start spinning: offset angle from centre, widened away from 90, saturated
	function automatic void steer(int b, dir_t d, logic [7:0] spd);
		int c;
		int s;
		int a;
		c = center_of(b);
		s = int'(spd);
		a = (d == DIR_UP) ? c - s : c + s;
		pwm_att[b] = 1'b1;
		spin[b] = d;
		if (d == DIR_DOWN && c > ANGLE_MID) a += c - ANGLE_MID;
		if (d == DIR_UP && c < ANGLE_MID) a -= ANGLE_MID - c;
		if (a > ANGLE_MAX) a = ANGLE_MAX;
		if (a < 0) a = 0;
		angle_now[b] = 8'(a);
	endfunction

	// move request, refused when moving the other way, on the endstop or at the end
	function automatic void try_move(int b, dir_t d, logic [31:0] dur, logic [7:0] spd,
			logic [31:0] t, logic [7:0] bot, logic [7:0] top,
			output logic hit, output reason_t why);
		hit = 1'b1;
		why = RSN_SYSTEM;
		if (d == DIR_DOWN) begin
			if (spin[b] == DIR_UP) why = RSN_SYSTEM;
			else if (switch_stops && bot[b]) why = RSN_BOTTOM_END;
			else if (rel_pos[b] == END_BOTTOM) why = RSN_AT_BOTTOM;
			else hit = 1'b0;
		end else begin
			if (spin[b] == DIR_DOWN) why = RSN_SYSTEM;
			else if (switch_stops && top[b]) why = RSN_TOP_END;
			else if (rel_pos[b] == END_TOP) why = RSN_AT_TOP;
			else hit = 1'b0;
		end
		if (hit) begin
			park(b, why);
		end else begin
			due[b] = t + dur;
			steer(b, d, spd);
		end
	endfunction

	function automatic void expect_report(int b, logic hit, reason_t why, logic is_last);
		blind_report_t r;
		r.w = '0;
		r.w.out_blind = BLIND_W'(b);
		r.w.servo_angle = angle_now[b];
		r.w.pwm_enabled = pwm_att[b];
		r.w.motion = spin[b];
		r.w.relative_end = rel_pos[b];
		r.w.absolute_end = abs_pos[b];
		r.w.stopped_now = hit;
		r.w.stop_reason = hit ? why : RSN_SYSTEM;
		r.last = is_last;
		reports_due.push_back(r);
	endfunction

	// expected result words of one accepted command
	function automatic void predict_command(func_t fn, in_word_t w);
		logic            hit;
		reason_t         why;
		logic [CW_W-1:0] cw;
		dir_t            cd;
		int              b;
		b = int'(w.blind);
		hit = 1'b0;
		why = RSN_SYSTEM;
		if (fn == FN_TICK) begin
			for (int s = 0; s < NUM_BLINDS; s++) begin
				hit = 1'b1;
				if (due[s] < w.now && spin[s] != DIR_NONE) why = RSN_TIMEOUT;
				else if (switch_stops && spin[s] == DIR_DOWN && w.bottom_switches[s])
					why = RSN_BOTTOM_END;
				else if (switch_stops && spin[s] == DIR_UP && w.top_switches[s])
					why = RSN_TOP_END;
				else hit = 1'b0;
				if (hit) park(s, why);
				if (due[s] < w.now && (w.now - due[s]) >= idle_timeout) pwm_att[s] = 1'b0;
				expect_report(s, hit, why, s == NUM_BLINDS - 1);
			end
			return;
		end
		if (fn == FN_STOP_ALL) begin
			for (int s = 0; s < NUM_BLINDS; s++) begin
				park(s, RSN_SYSTEM);
				expect_report(s, 1'b1, RSN_SYSTEM, s == NUM_BLINDS - 1);
			end
			return;
		end
		if (fn == FN_UNUSED || b >= NUM_BLINDS) return;
		case (fn)
			FN_UP, FN_DOWN: begin
				try_move(b, fn == FN_UP ? DIR_UP : DIR_DOWN, w.move_time, w.speed, w.now,
					w.bottom_switches, w.top_switches, hit, why);
			end
			FN_UPDOWN: begin
				preset[b] = '0;
				if (w.direction == DIR_UP || w.direction == DIR_DOWN)
					try_move(b, dir_t'(w.direction), w.move_time, w.speed, w.now,
						w.bottom_switches, w.top_switches, hit, why);
			end
			FN_RUN: begin
				if (w.cycle_index < NUM_CYCLES) begin
					cw = cycle_set[w.cycle_index];
					cd = dir_t'(cw[1:0]);
					preset[b] = {1'b0, w.cycle_index} + 3'd1;
					if (cd == DIR_UP || cd == DIR_DOWN)
						try_move(b, cd, cw[CW_W-1:CW_DUR_LSB], cw[CW_DUR_LSB-1:CW_SPD_LSB],
							w.now, w.bottom_switches, w.top_switches, hit, why);
				end
			end
			default: begin
				park(b, RSN_SYSTEM);
				hit = 1'b1;
			end
		endcase
		expect_report(b, hit, why, 1'b1);
	endfunction

	function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			n_errors++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
		end
	endfunction

	// compare one result word with the oldest expectation
	function automatic void check_word(out_word_t got, logic got_last);
		blind_report_t e;
		if (reports_due.size() == 0) begin
			n_errors++;
			$display("%0t: unexpected result word, expected none, actual %h last %b",
				$time, got, got_last);
			return;
		end
		e = reports_due.pop_front();
		check_field("out_blind", e.w.out_blind, got.out_blind);
		check_field("servo_angle", e.w.servo_angle, got.servo_angle);
		check_field("pwm_enabled", e.w.pwm_enabled, got.pwm_enabled);
		check_field("motion", e.w.motion, got.motion);
		check_field("relative_end", e.w.relative_end, got.relative_end);
		check_field("absolute_end", e.w.absolute_end, got.absolute_end);
		check_field("stopped_now", e.w.stopped_now, got.stopped_now);
		check_field("stop_reason", e.w.stop_reason, got.stop_reason);
		check_field("tlast", e.last, got_last);
	endfunction

	// sampling at the rising edge: handshakes, checks and predictions
	always @(posedge clk) begin
		s_fire <= arst_n && s_tvalid && s_tready;
		m_fire <= arst_n && m_tvalid && m_tready;
		if (arst_n) begin
			if (m_tvalid && m_tready) check_word(out_word_t'(m_tdata), m_tlast);
			if (s_tvalid && s_tready) begin
				predict_command(func_t'(s_tuser), in_word_t'(s_tdata));
				cmds_taken++;
			end
		end
	end

	// command driver, one word per handshake, random gap after each
	always @(negedge clk) begin : cmd_driver
		blind_cmd_t cmd;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			src_wait = 0;
		end else if (!s_tvalid || s_fire) begin
			if (s_fire) src_wait = steady ? 0 : $urandom_range(0, 14);
			if (src_wait > 0) begin
				src_wait--;
				s_tvalid <= 1'b0;
			end else if (cmd_queue.size() != 0) begin
				cmd = cmd_queue.pop_front();
				s_tdata <= cmd.w;
				s_tuser <= cmd.fn;
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// result receiver, random hold-off per word and one long stall
	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_fire) begin
				rx_words++;
				rx_wait = steady ? 0 : $urandom_range(0, 14);
			end
			if (!stall_done && rx_words >= 150) begin
				stall_done = 1'b1;
				stall_left = 400;
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (rx_wait > 0) begin
				rx_wait--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	function automatic void send(func_t fn, logic [2:0] b, logic [1:0] d, logic [31:0] dur,
			logic [7:0] spd, logic [1:0] ci, logic [31:0] t, logic [7:0] bot,
			logic [7:0] top);
		blind_cmd_t cmd;
		cmd.fn = fn;
		cmd.w = '0;
		cmd.w.blind = b;
		cmd.w.direction = d;
		cmd.w.move_time = dur;
		cmd.w.speed = spd;
		cmd.w.cycle_index = ci;
		cmd.w.now = t;
		cmd.w.bottom_switches = bot;
		cmd.w.top_switches = top;
		cmd_queue.push_back(cmd);
		cmds_queued++;
	endfunction

	function automatic logic [7:0] rand_switches();
		return ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h00;
	endfunction

	// random commands on an advancing millisecond clock, mostly short moves
	function automatic void queue_random(int count);
		int          pick;
		logic [31:0] dur;
		func_t       fn;
		repeat (count) begin
			clock_ms += ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, 25);
			dur = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 60);
			pick = $urandom_range(0, 99);
			if (pick < 35) fn = FN_TICK;
			else if (pick < 50) fn = FN_UP;
			else if (pick < 65) fn = FN_DOWN;
			else if (pick < 75) fn = FN_UPDOWN;
			else if (pick < 87) fn = FN_RUN;
			else if (pick < 93) fn = FN_STOP;
			else if (pick < 97) fn = FN_STOP_ALL;
			else fn = FN_UNUSED;
			send(fn, 3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)), dur, 8'($urandom),
				2'($urandom_range(0, 3)), clock_ms, rand_switches(), rand_switches());
		end
	endfunction

	// register write over the configuration port, mirrored into the model
	task automatic reg_write(logic [REG_IDX_W-1:0] idx, logic [63:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_CENTER:   center_tbl = val;
			REG_TIMEOUT:  idle_timeout = val[31:0];
			REG_ENDSTOPS: switch_stops = val[0];
			default:      cycle_set[idx - REG_CYCLE0] = val[CW_W-1:0];
		endcase
	endtask

	// all commands taken and all words back, then let the sequencer settle
	task automatic wait_idle();
		do @(negedge clk); while (cmds_taken != cmds_queued || reports_due.size() != 0);
		repeat (40) @(negedge clk);
	endtask

	// stimulus and verdict
	initial begin
		logic [63:0] cw;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed commands on the reset settings, all centres at 90
		send(FN_TICK, 0, DIR_NONE, 0, 0, 0, 32'd0, 8'h00, 8'h00);
		send(FN_UP, 0, DIR_NONE, 100, 8'h00, 0, 32'd10, 8'h00, 8'h01);
		send(FN_DOWN, 1, DIR_NONE, 100, 8'hFF, 0, 32'd10, 8'h02, 8'h00);
		send(FN_DOWN, 1, DIR_NONE, 100, 8'h10, 0, 32'd11, 8'h00, 8'h00);
		send(FN_UP, 0, DIR_NONE, 100, 8'h10, 0, 32'd12, 8'h00, 8'h00);
		send(FN_UP, 2, DIR_NONE, 50, 8'hFF, 0, 32'd20, 8'h00, 8'h00);
		send(FN_UP, 2, DIR_NONE, 50, 8'h00, 0, 32'd21, 8'h00, 8'h00);
		send(FN_DOWN, 2, DIR_NONE, 50, 8'h01, 0, 32'd22, 8'h00, 8'h00);
		// deadline wraps past zero
		send(FN_DOWN, 3, DIR_NONE, 32'hFFFF_FFFF, 8'd40, 0, 32'd30, 8'h00, 8'h00);
		send(FN_TICK, 0, DIR_NONE, 0, 0, 0, 32'd31, 8'h00, 8'h00);
		send(FN_UPDOWN, 4, DIR_DOWN, 5, 8'd10, 0, 32'd40, 8'h00, 8'h00);
		send(FN_TICK, 0, DIR_NONE, 0, 0, 0, 32'd41, 8'h10, 8'h00);
		send(FN_UPDOWN, 5, DIR_UP, 5, 8'd200, 0, 32'd42, 8'h00, 8'h00);
		send(FN_TICK, 0, DIR_NONE, 0, 0, 0, 32'd43, 8'h00, 8'h20);
		send(FN_UPDOWN, 6, DIR_NONE, 5, 8'd7, 0, 32'd44, 8'h00, 8'h00);
		send(FN_UPDOWN, 6, DIR_BAD, 5, 8'd7, 0, 32'd45, 8'h00, 8'h00);
		// preset with no direction only arms the cycle
		send(FN_RUN, 7, DIR_NONE, 0, 0, 3, 32'd46, 8'h00, 8'h00);
		send(FN_STOP, 2, DIR_NONE, 0, 0, 0, 32'd47, 8'h00, 8'h00);
		send(FN_UNUSED, 0, DIR_NONE, 0, 0, 0, 32'd48, 8'h00, 8'h00);
		send(FN_TICK, 0, DIR_NONE, 0, 0, 0, 32'hFFFF_FFFF, 8'hFF, 8'hFF);
		send(FN_DOWN, 0, DIR_NONE, 32'hFFFF_FFFF, 8'hFF, 0, 32'hFFFF_FFFF, 8'h00, 8'h00);
		send(FN_STOP_ALL, 0, DIR_NONE, 0, 0, 0, 32'hFFFF_FFFF, 8'h00, 8'h00);
		clock_ms = 32'd100;
		queue_random(28);

		// register settings: mixed extremes, all ones, all zeros, then random
		for (int k = 1; k <= 5; k++) begin
			wait_idle();
			case (k)
				1: reg_write(REG_CENTER, 64'h2D5B_595A_B5B4_FF00);
				2: reg_write(REG_CENTER, '1);
				3: reg_write(REG_CENTER, '0);
				default: reg_write(REG_CENTER, {$urandom, $urandom});
			endcase
			case (k)
				2: reg_write(REG_TIMEOUT, 64'hFFFF_FFFF);
				3: reg_write(REG_TIMEOUT, 64'd0);
				5: reg_write(REG_TIMEOUT, 64'($urandom));
				default: reg_write(REG_TIMEOUT, 64'($urandom_range(0, 40)));
			endcase
			reg_write(REG_ENDSTOPS, (k == 2) ? 64'd0 : (k == 4) ? 64'($urandom_range(0, 1))
				: 64'd1);
			for (int c = 0; c < NUM_CYCLES; c++) begin
				cw = {22'd0, ($urandom_range(0, 4) == 0) ? $urandom
					: 32'($urandom_range(0, 60)), 8'($urandom), 2'($urandom_range(0, 3))};
				if (k == 2) cw = 64'h3FF_FFFF_FFFF;
				if (k == 3) cw = '0;
				reg_write(REG_IDX_W'(REG_CYCLE0 + c), cw);
			end
			@(posedge clk);
			steady = (k == 3);
			if (k == 5) clock_ms = $urandom;
			queue_random(36);
		end

		wait_idle();
		if (n_errors == 0 && reports_due.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// run limit
	initial begin
		#3000000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
